### rtl/core/sdte_pkg.sv
package sdte_pkg;

	localparam int NCH       = 4;
	localparam int WIN_LEN   = 256;
	localparam int IDX_W     = $clog2(WIN_LEN);
	localparam int SMP_W     = 16;
	localparam int ENERGY_W  = 39;
	localparam int BIN_W     = 40;
	localparam int RATIO_W   = 25;
	localparam int POW_W     = 80;
	localparam int QUO_W     = 24;
	localparam int SQ_STEPS  = 3;
	localparam int DIV_STEPS = QUO_W + 1;
	localparam int CNT_W     = $clog2(DIV_STEPS);
	localparam int CFG_IDX_W = 3;

	localparam logic [RATIO_W-1:0] RATIO_SAT = RATIO_W'(1) << QUO_W;

	localparam logic [CFG_IDX_W-1:0] REG_OFFSET0    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET1    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET2    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET3    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TWIDDLE_RE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TWIDDLE_IM = 3'd5;

	localparam logic signed [SMP_W-1:0] OFFSET0_RST    = -16'sd479;
	localparam logic signed [SMP_W-1:0] OFFSET1_RST    = -16'sd800;
	localparam logic signed [SMP_W-1:0] OFFSET2_RST    = -16'sd757;
	localparam logic signed [SMP_W-1:0] OFFSET3_RST    = -16'sd1934;
	localparam logic signed [SMP_W-1:0] TWIDDLE_RE_RST = 16'sd31581;
	localparam logic signed [SMP_W-1:0] TWIDDLE_IM_RST = -16'sd8740;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROD,
		ST_MUL,
		ST_SUM,
		ST_SQ,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic       prod;
		logic       mul;
		logic       sum;
		logic       sq;
		logic [1:0] sq_step;
		logic       div_init;
		logic       div_step;
	} ctrl_t;

endpackage

### rtl/core/sdte_div.sv
module sdte_div (
	input  logic                          clk,
	input  logic                          init,
	input  logic                          step,
	input  logic [sdte_pkg::POW_W-1:0]    pow,
	input  logic [sdte_pkg::ENERGY_W-1:0] energy,
	output logic [sdte_pkg::RATIO_W-1:0]  ratio
);
	import sdte_pkg::*;

	logic [POW_W-1:0] rem_q;
	logic [POW_W-1:0] den_q;
	logic [QUO_W-1:0] quo_q;
	logic             sat_q;
	logic             zero_q;

	// divisor is energy * 2^14, first quotient bit weighs 2^23
	always_ff @(posedge clk) begin
		if (init) begin
			rem_q  <= pow;
			den_q  <= POW_W'(energy) << 37;
			quo_q  <= '0;
			sat_q  <= pow >= (POW_W'(energy) << 38);
			zero_q <= energy == '0;
		end else if (step) begin
			if (rem_q >= den_q) begin
				rem_q <= rem_q - den_q;
				quo_q <= {quo_q[QUO_W-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[QUO_W-2:0], 1'b0};
			end
			den_q <= den_q >> 1;
		end
	end

	always_comb begin
		if (zero_q) begin
			ratio = '0;
		end else if (sat_q) begin
			ratio = RATIO_SAT;
		end else begin
			ratio = {1'b0, quo_q};
		end
	end
endmodule

### rtl/core/sdte_lane.sv
module sdte_lane (
	input  logic                               clk,
	input  logic                               arst_n,
	input  sdte_pkg::ctrl_t                    ctrl,
	input  logic signed [sdte_pkg::SMP_W-1:0]  raw,
	input  logic signed [sdte_pkg::SMP_W-1:0]  offset,
	input  logic signed [sdte_pkg::SMP_W-1:0]  old,
	input  logic signed [sdte_pkg::SMP_W-1:0]  tw_re,
	input  logic signed [sdte_pkg::SMP_W-1:0]  tw_im,
	output logic signed [sdte_pkg::SMP_W-1:0]  corr,
	output logic [sdte_pkg::RATIO_W-1:0]       ratio,
	output logic [sdte_pkg::ENERGY_W-1:0]      energy
);
	import sdte_pkg::*;

	logic signed [SMP_W:0]     diff;
	logic signed [2*SMP_W-1:0] sq_new;
	logic signed [2*SMP_W-1:0] sq_old;
	logic signed [BIN_W:0]     t_re;

	logic [2*SMP_W-1:0]        sq_new_s1;
	logic [2*SMP_W-1:0]        sq_old_s1;
	logic signed [BIN_W:0]     t_re_s1;
	logic signed [BIN_W-1:0]   t_im_s1;

	logic signed [BIN_W+SMP_W:0]   prr_s2, pii_s2, pri_s2, pir_s2;
	logic signed [BIN_W+SMP_W+1:0] sum_re, sum_im;

	logic signed [BIN_W-1:0] bin_re_q;
	logic signed [BIN_W-1:0] bin_im_q;
	logic [ENERGY_W-1:0]     energy_q;
	logic [ENERGY_W:0]       energy_nx;

	logic [BIN_W-1:0]   abs_re, abs_im;
	logic [BIN_W/2-1:0] op_a_re, op_b_re, op_a_im, op_b_im;
	logic [BIN_W-1:0]   part_re, part_im;
	logic [POW_W-1:0]   add_re, add_im;
	logic [POW_W-1:0]   pow_q;

	assign corr   = raw - offset;
	assign diff   = (SMP_W+1)'(corr) - (SMP_W+1)'(old);
	assign sq_new = corr * corr;
	assign sq_old = old * old;
	assign t_re   = (BIN_W+1)'(bin_re_q) + ((BIN_W+1)'(diff) <<< 15);

	always_ff @(posedge clk) begin
		if (ctrl.prod) begin
			sq_new_s1 <= sq_new;
			sq_old_s1 <= sq_old;
			t_re_s1   <= t_re;
			t_im_s1   <= bin_im_q;
		end
		if (ctrl.mul) begin
			prr_s2 <= t_re_s1 * tw_re;
			pii_s2 <= t_im_s1 * tw_im;
			pri_s2 <= t_re_s1 * tw_im;
			pir_s2 <= t_im_s1 * tw_re;
		end
	end

	assign energy_nx = (ENERGY_W+1)'(energy_q) + (ENERGY_W+1)'(sq_new_s1)
		- (ENERGY_W+1)'(sq_old_s1);

	// rounding constant is half an lsb of the Q.15 product
	assign sum_re = (BIN_W+SMP_W+2)'(prr_s2) - (BIN_W+SMP_W+2)'(pii_s2) + 16384;
	assign sum_im = (BIN_W+SMP_W+2)'(pri_s2) + (BIN_W+SMP_W+2)'(pir_s2) + 16384;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			energy_q <= '0;
			bin_re_q <= '0;
			bin_im_q <= '0;
		end else begin
			if (ctrl.mul) begin
				energy_q <= energy_nx[ENERGY_W-1:0];
			end
			if (ctrl.sum) begin
				bin_re_q <= sum_re[BIN_W+14:15];
				bin_im_q <= sum_im[BIN_W+14:15];
			end
		end
	end

	// square of 40-bit magnitude from three 20x20 partials
	assign abs_re = bin_re_q[BIN_W-1] ? BIN_W'(-bin_re_q) : BIN_W'(bin_re_q);
	assign abs_im = bin_im_q[BIN_W-1] ? BIN_W'(-bin_im_q) : BIN_W'(bin_im_q);

	always_comb begin
		case (ctrl.sq_step)
			2'd0: begin
				op_a_re = abs_re[BIN_W-1:BIN_W/2];
				op_b_re = abs_re[BIN_W-1:BIN_W/2];
				op_a_im = abs_im[BIN_W-1:BIN_W/2];
				op_b_im = abs_im[BIN_W-1:BIN_W/2];
			end
			2'd1: begin
				op_a_re = abs_re[BIN_W-1:BIN_W/2];
				op_b_re = abs_re[BIN_W/2-1:0];
				op_a_im = abs_im[BIN_W-1:BIN_W/2];
				op_b_im = abs_im[BIN_W/2-1:0];
			end
			default: begin
				op_a_re = abs_re[BIN_W/2-1:0];
				op_b_re = abs_re[BIN_W/2-1:0];
				op_a_im = abs_im[BIN_W/2-1:0];
				op_b_im = abs_im[BIN_W/2-1:0];
			end
		endcase
	end

	assign part_re = op_a_re * op_b_re;
	assign part_im = op_a_im * op_b_im;

	always_comb begin
		case (ctrl.sq_step)
			2'd0: begin
				add_re = POW_W'(part_re) << BIN_W;
				add_im = POW_W'(part_im) << BIN_W;
			end
			2'd1: begin
				add_re = POW_W'(part_re) << (BIN_W/2 + 1);
				add_im = POW_W'(part_im) << (BIN_W/2 + 1);
			end
			default: begin
				add_re = POW_W'(part_re);
				add_im = POW_W'(part_im);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.sq) begin
			pow_q <= ((ctrl.sq_step == 2'd0) ? '0 : pow_q) + add_re + add_im;
		end
	end

	sdte_div u_div (
		.clk    (clk),
		.init   (ctrl.div_init),
		.step   (ctrl.div_step),
		.pow    (pow_q),
		.energy (energy_q),
		.ratio  (ratio)
	);

	assign energy = energy_q;
endmodule

### rtl/core/sliding_dft_tone_energy_top.sv
// channel  dir  handshake                  contents
// s_axis   in   s_axis_tvalid/tready       one frame of four raw samples
// m_axis   out  m_axis_tvalid/tready       four ratios then four energies
// cfg      in   cfg_valid/cfg_ready        register index and 16-bit value
//
// one word passes through accept, three recurrence stages, the squaring steps,
// the restoring divider (one quotient bit a cycle) and the load of the output
// register, which waits until the output register is free
// the next word is taken while a result waits in the output register
// cfg_ready is always high; reset clears state and the window reads as zero
// until the write pointer has wrapped once
module sliding_dft_tone_energy_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [63:0]                        s_axis_tdata,   // sample_ch0..sample_ch3
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [255:0]                       m_axis_tdata,   // ratio_ch0..3, energy_ch0..3
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [sdte_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [15:0]                        cfg_data
);
	import sdte_pkg::*;

	state_t state_q, state_nx;
	logic [CNT_W-1:0] cnt_q;
	ctrl_t ctrl;

	logic signed [SMP_W-1:0] off_q [NCH];
	logic signed [SMP_W-1:0] tw_re_q, tw_im_q;

	logic [NCH*SMP_W-1:0] mem [WIN_LEN];
	logic [NCH*SMP_W-1:0] rd_q;
	logic [NCH*SMP_W-1:0] samp_q;
	logic [NCH*SMP_W-1:0] wr_word;
	logic [IDX_W-1:0]     idx_q;
	logic                 wrapped_q;

	logic signed [SMP_W-1:0]  corr   [NCH];
	logic [RATIO_W-1:0]       ratio  [NCH];
	logic [ENERGY_W-1:0]      energy [NCH];

	logic          out_valid_q;
	logic [255:0]  out_data_q;
	logic          out_free;
	logic          accept;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || m_axis_tready;
	assign s_axis_tready = state_q == ST_IDLE;
	assign accept    = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q[0] <= OFFSET0_RST;
			off_q[1] <= OFFSET1_RST;
			off_q[2] <= OFFSET2_RST;
			off_q[3] <= OFFSET3_RST;
			tw_re_q  <= TWIDDLE_RE_RST;
			tw_im_q  <= TWIDDLE_IM_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_OFFSET0:    off_q[0] <= cfg_data;
				REG_OFFSET1:    off_q[1] <= cfg_data;
				REG_OFFSET2:    off_q[2] <= cfg_data;
				REG_OFFSET3:    off_q[3] <= cfg_data;
				REG_TWIDDLE_RE: tw_re_q  <= cfg_data;
				REG_TWIDDLE_IM: tw_im_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			if ((state_q == ST_SQ && cnt_q != CNT_W'(SQ_STEPS - 1)) ||
			    (state_q == ST_DIV && cnt_q != CNT_W'(DIV_STEPS - 1))) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: if (s_axis_tvalid) state_nx = ST_PROD;
			ST_PROD: state_nx = ST_MUL;
			ST_MUL:  state_nx = ST_SUM;
			ST_SUM:  state_nx = ST_SQ;
			ST_SQ:   if (cnt_q == CNT_W'(SQ_STEPS - 1)) state_nx = ST_DIV;
			ST_DIV:  if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_nx = ST_FIN;
			ST_FIN:  if (out_free) state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl          = '0;
		ctrl.sq_step  = cnt_q[1:0];
		case (state_q)
			ST_PROD: ctrl.prod = 1'b1;
			ST_MUL:  ctrl.mul  = 1'b1;
			ST_SUM:  ctrl.sum  = 1'b1;
			ST_SQ:   ctrl.sq   = 1'b1;
			ST_DIV: begin
				ctrl.div_init = cnt_q == '0;
				ctrl.div_step = cnt_q != '0;
			end
			default: ;
		endcase
	end

	// window memory: read at accept, write back corrected frame in the cycle after
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q   <= mem[idx_q];
			samp_q <= s_axis_tdata;
		end
		if (ctrl.prod) begin
			mem[idx_q] <= wr_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			wrapped_q <= 1'b0;
		end else if (ctrl.prod) begin
			idx_q <= idx_q + 1'b1;
			if (idx_q == IDX_W'(WIN_LEN - 1)) begin
				wrapped_q <= 1'b1;
			end
		end
	end

	for (genvar c = 0; c < NCH; c++) begin : g_lane
		logic signed [SMP_W-1:0] old;
		assign old = wrapped_q ? rd_q[c*SMP_W +: SMP_W] : '0;
		assign wr_word[c*SMP_W +: SMP_W] = corr[c];

		sdte_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.raw    (samp_q[c*SMP_W +: SMP_W]),
			.offset (off_q[c]),
			.old    (old),
			.tw_re  (tw_re_q),
			.tw_im  (tw_im_q),
			.corr   (corr[c]),
			.ratio  (ratio[c]),
			.energy (energy[c])
		);
	end

	// merge lane results into the output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			for (int c = 0; c < NCH; c++) begin
				out_data_q[c*RATIO_W +: RATIO_W] <= ratio[c];
				out_data_q[NCH*RATIO_W + c*ENERGY_W +: ENERGY_W] <= energy[c];
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_PROD)
		else $error("accepted word did not start the recurrence");

	a_wrap_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(wrapped_q))
		else $error("window wrap flag cleared");

	a_load_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN))
		else $error("output loaded outside final state");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < CNT_W'(DIV_STEPS))
		else $error("step counter out of range");
endmodule

### tb/sliding_dft_tone_energy_top_tb.sv
module sliding_dft_tone_energy_top_tb;

	import sdte_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 40;

	typedef struct {
		logic [24:0] ratio  [4];
		logic [38:0] energy [4];
	} tone_result_t;

	class tone_scoreboard;
		logic [15:0]     regs [6];
		logic [15:0]     window [WIN_LEN][4];
		int              widx;
		longint          energy [4];
		longint          bin_re [4];
		longint          bin_im [4];
		tone_result_t    pending [$];
		int              errors;

		function void clear();
			regs[REG_OFFSET0]    = OFFSET0_RST;
			regs[REG_OFFSET1]    = OFFSET1_RST;
			regs[REG_OFFSET2]    = OFFSET2_RST;
			regs[REG_OFFSET3]    = OFFSET3_RST;
			regs[REG_TWIDDLE_RE] = TWIDDLE_RE_RST;
			regs[REG_TWIDDLE_IM] = TWIDDLE_IM_RST;
			foreach (window[i, c]) window[i][c] = '0;
			widx = 0;
			errors = 0;
			for (int c = 0; c < 4; c++) begin
				energy[c] = 0;
				bin_re[c] = 0;
				bin_im[c] = 0;
			end
		endfunction

		function void write_reg(logic [2:0] idx, logic [15:0] val);
			if (idx < 6)
				regs[idx] = val;
		endfunction

		// back from q.30 to q.15 with rounding, wrapped to the 40-bit accumulator
		function longint rescale(longint p);
			longint v;
			v = (p + 16384) >>> 15;
			return longint'($signed(v[39:0]));
		endfunction

		function logic [24:0] bin_ratio(longint re, longint im, longint e);
			logic [127:0] pw, d;
			logic [127:0] q;
			longint       ar, ai;
			ar = re < 0 ? -re : re;
			ai = im < 0 ? -im : im;
			if (e == 0)
				return '0;
			pw = 128'(ar) * 128'(ar) + 128'(ai) * 128'(ai);
			d  = 128'(e) << 14;
			if (pw >= (d << 24))
				return RATIO_SAT;
			q = pw / d;
			return q[24:0];
		endfunction

		function void note_frame(logic [63:0] frame);
			tone_result_t r;
			logic [15:0]  s;
			longint       sn, so, wr, wi, t_re, t_im;
			wr = longint'($signed(regs[REG_TWIDDLE_RE]));
			wi = longint'($signed(regs[REG_TWIDDLE_IM]));
			for (int c = 0; c < 4; c++) begin
				s  = frame[16*c +: 16] - regs[c];
				sn = longint'($signed(s));
				so = longint'($signed(window[widx][c]));
				energy[c] = energy[c] - so * so + sn * sn;
				t_re = bin_re[c] + (sn - so) * 32768;
				t_im = bin_im[c];
				bin_re[c] = rescale(t_re * wr - t_im * wi);
				bin_im[c] = rescale(t_re * wi + t_im * wr);
				window[widx][c] = s;
				r.ratio[c]  = bin_ratio(bin_re[c], bin_im[c], energy[c]);
				r.energy[c] = energy[c][38:0];
			end
			widx = (widx + 1) % WIN_LEN;
			pending.push_back(r);
		endfunction

		function void check_word(logic [255:0] w);
			tone_result_t e;
			logic         bad;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("result word with nothing expected: %h", w);
				return;
			end
			e = pending.pop_front();
			bad = 1'b0;
			for (int c = 0; c < 4; c++) begin
				if (w[25*c +: 25] !== e.ratio[c]) begin
					bad = 1'b1;
					if (errors < 10)
						$display("ratio_ch%0d: expected %0d got %0d", c, e.ratio[c],
							w[25*c +: 25]);
				end
				if (w[100 + 39*c +: 39] !== e.energy[c]) begin
					bad = 1'b1;
					if (errors < 10)
						$display("energy_ch%0d: expected %0d got %0d", c, e.energy[c],
							w[100 + 39*c +: 39]);
				end
			end
			if (bad)
				errors++;
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [63:0]  s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [255:0] m_axis_tdata;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [2:0]   cfg_index;
	logic [15:0]  cfg_data;

	tone_scoreboard sb;
	int             send_idle_pct;
	int             recv_stall_pct;
	int             quiet_cycles;
	logic           moved;

	sliding_dft_tone_energy_top dut (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

	// a handshake seen at the falling edge completes at the next rising edge
	always @(negedge clk) begin
		moved = 1'b0;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			sb.check_word(m_axis_tdata);
			moved = 1'b1;
		end
		if (s_axis_tvalid && s_axis_tready)
			moved = 1'b1;
		if (cfg_valid && cfg_ready)
			moved = 1'b1;
		quiet_cycles = moved ? 0 : quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send_frame(logic [63:0] frame);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= frame;
		@(negedge clk);
		while (!s_axis_tready)
			@(negedge clk);
		@(posedge clk);
		sb.note_frame(frame);
	endtask

	// cfg_valid stays high after the last write; the caller drops it
	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		s_axis_tvalid <= 1'b0;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		while (!cfg_ready)
			@(negedge clk);
		@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_extreme();
		case ($urandom_range(4))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'hffff;
			default: return 16'h0001;
		endcase
	endfunction

	// sample for one channel in the style of the given phase
	function automatic logic [15:0] pick_sample(int style, int c);
		case (style)
			0: return 16'($urandom);
			1: return sb.regs[c] + 16'($signed($urandom_range(30)) - 15);
			2: return ($urandom_range(99) < 97) ? sb.regs[c] : 16'($urandom);
			default: return ($urandom_range(1)) ? pick_extreme() : 16'($urandom);
		endcase
	endfunction

	initial begin
		logic [63:0] f;
		sb = new();
		sb.clear();
		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		m_axis_tready  = 1'b0;
		cfg_valid      = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		quiet_cycles   = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes on each channel, then a quiet input
		for (int i = 0; i < 20; i++) begin
			for (int c = 0; c < 4; c++)
				f[16*c +: 16] = (i < 16) ? pick_extreme() : sb.regs[c];
			if (i == 0) f = {4{16'h8000}};
			if (i == 1) f = {4{16'h7fff}};
			if (i == 2) f = '0;
			send_frame(f);
		end
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
				default: begin send_idle_pct = 14; recv_stall_pct = 14; end
			endcase
			for (int r = 0; r < 6; r++) begin
				case (ph)
					0: write_reg(3'(r), 16'h8000);
					1: write_reg(3'(r), 16'h7fff);
					2: write_reg(3'(r), 16'h0000);
					default: write_reg(3'(r), 16'($urandom));
				endcase
			end
			// indexes past the register file must be ignored
			write_reg(3'd6, 16'($urandom));
			write_reg(3'd7, 16'($urandom));
			cfg_valid <= 1'b0;
			for (int i = 0; i < 200; i++) begin
				for (int c = 0; c < 4; c++)
					f[16*c +: 16] = pick_sample((ph + (i >= 100 ? 2 : 0)) % 4, c);
				send_frame(f);
			end
			drain();
		end

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### filelist.f
rtl/core/sdte_pkg.sv
rtl/core/sdte_div.sv
rtl/core/sdte_lane.sv
rtl/core/sliding_dft_tone_energy_top.sv
tb/sliding_dft_tone_energy_top_tb.sv
